// ===== rtl/core/dense_component_table_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the dense component table
// ---------------------------------------------------------------------------
`ifndef DENSE_COMPONENT_TABLE_ASSERT_SVH
`define DENSE_COMPONENT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// property check on the rising clock edge, quiet while reset is held
`define DCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never hold
`define DCT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DCT_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define DCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DCT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/dct_pkg.sv =====
// ---------------------------------------------------------------------------
// dct_pkg
// shared word types and codes of the dense component table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dct_pkg;

  localparam int unsigned ENTITY_W = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_GET     = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                command;
    logic [ENTITY_W-1:0] entity;
    logic [VALUE_W-1:0]  value_in;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic                found;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

endpackage

// ===== rtl/core/dct_ent_map.sv =====
// ---------------------------------------------------------------------------
// dct_ent_map
// per-entity memory holding {present, slot}, swept to zero after reset
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_ent_map #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] rd_addr_i,
  output logic [AW:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [AW:0]   wr_data_i,
  output logic          clearing_o
);

  logic [AW:0]   mem [DEPTH];
  logic [AW:0]   rd_data_q;
  logic [AW-1:0] clr_idx_q;
  logic          clearing_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW:0]   mem_wdata;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == AW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign mem_we    = clearing_q | wr_en_i;
  assign mem_waddr = clearing_q ? clr_idx_q : wr_addr_i;
  assign mem_wdata = clearing_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

// ===== rtl/core/dense_component_table.sv =====
// ---------------------------------------------------------------------------
// dense_component_table
// sparse set: one value per entity, values packed densely by slot.
// an add or a miss resolves in the look state, a get hit goes on through the
// value state, a remove or destroy hit through the move state; busy holds
// until the registered result shows, so no new request is taken before the
// last is through. the pace is set by the chain of registered memory reads
// (entity map, then slot store) and the second write-back through the one
// write port of the entity map. reset: count and control clear at once,
// then busy stays high while the entity map is swept clear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dense_component_table_assert.svh"

module dense_component_table #(
  parameter int unsigned MAX_ENTITIES = 1024,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dct_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output dct_pkg::rsp_t rsp_o
);

  import dct_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTITIES);
  localparam int unsigned CW = $clog2(MAX_ENTITIES + 1);
  localparam int unsigned SW = IW + VALUE_BITS;

  // one-hot sequencer
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_VALUE = 4'b0100,
    ST_MOVE  = 4'b1000
  } state_e;

  function automatic rsp_t pack_rsp(status_e st, logic fnd, logic [VALUE_W-1:0] val,
                                    logic [SLOT_W-1:0] sl, logic [COUNT_W-1:0] cnt);
    rsp_t r;
    r.status    = st;
    r.found     = fnd;
    r.value_out = val;
    r.slot      = sl;
    r.count     = cnt;
    return r;
  endfunction

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic [IW-1:0]         ent_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  in_range_q;
  logic [IW-1:0]         slot_q, slot_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rsp_valid_q, rsp_valid_d;
  rsp_t                  rsp_q, rsp_d;

  logic                  accept;
  logic                  clearing;
  logic                  in_range;

  // entity map port
  logic [IW-1:0]         em_raddr;
  logic [IW:0]           em_rdata;
  logic                  em_we;
  logic [IW-1:0]         em_waddr;
  logic [IW:0]           em_wdata;

  // slot store: {entity, value} per dense slot
  logic [SW-1:0]         slot_mem [MAX_ENTITIES];
  logic [IW-1:0]         sm_raddr;
  logic [SW-1:0]         sm_rdata_q;
  logic                  sm_we;
  logic [IW-1:0]         sm_waddr;
  logic [SW-1:0]         sm_wdata;

  // decoded read data
  logic                  here;
  logic [IW-1:0]         hit_slot;
  logic [IW-1:0]         moved_ent;
  logic [VALUE_BITS-1:0] moved_val;
  logic [IW-1:0]         last_idx;
  logic                  full;

  dct_ent_map #(
    .DEPTH (MAX_ENTITIES)
  ) u_ent_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (em_raddr),
    .rd_data_o  (em_rdata),
    .wr_en_i    (em_we),
    .wr_addr_i  (em_waddr),
    .wr_data_i  (em_wdata),
    .clearing_o (clearing)
  );

  assign busy     = (state_q != ST_IDLE) | clearing;
  assign accept   = start & ~busy;
  // ids at or above the table depth behave as absent
  assign in_range = 32'(req_i.entity) < 32'(MAX_ENTITIES);

  assign hit_slot  = em_rdata[IW-1:0];
  assign here      = in_range_q & em_rdata[IW];
  assign moved_ent = sm_rdata_q[SW-1:VALUE_BITS];
  assign moved_val = sm_rdata_q[VALUE_BITS-1:0];
  assign last_idx  = IW'(count_q - 1'b1);
  assign full      = count_q == CW'(MAX_ENTITIES);

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    count_d     = count_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    // at accept: look up the entity and prefetch the last slot for a move
    em_raddr    = IW'(req_i.entity);
    em_we       = 1'b0;
    em_waddr    = ent_q;
    em_wdata    = '0;
    sm_raddr    = last_idx;
    sm_we       = 1'b0;
    sm_waddr    = hit_slot;
    sm_wdata    = sm_rdata_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end

      ST_LOOK: begin
        slot_d   = hit_slot;
        sm_raddr = hit_slot;  // value fetch for a get hit
        unique case (cmd_q)
          CMD_ADD: begin
            state_d     = ST_IDLE;
            rsp_valid_d = 1'b1;
            priority if (!in_range_q) begin
              rsp_d = pack_rsp(STAT_NOT_FOUND, 1'b0, '0, '0, COUNT_W'(count_q));
            end else if (here) begin
              rsp_d = pack_rsp(STAT_DUPLICATE, 1'b1, '0, SLOT_W'(hit_slot),
                               COUNT_W'(count_q));
            end else if (full) begin
              rsp_d = pack_rsp(STAT_FULL, 1'b0, '0, '0, COUNT_W'(count_q));
            end else begin
              // append at the end of the dense array
              em_we    = 1'b1;
              em_waddr = ent_q;
              em_wdata = {1'b1, IW'(count_q)};
              sm_we    = 1'b1;
              sm_waddr = IW'(count_q);
              sm_wdata = {ent_q, val_q};
              count_d  = count_q + 1'b1;
              rsp_d    = pack_rsp(STAT_DONE, 1'b0, '0, SLOT_W'(count_q),
                                  COUNT_W'(count_d));
            end
          end

          CMD_GET: begin
            if (here) begin
              state_d = ST_VALUE;
            end else begin
              state_d     = ST_IDLE;
              rsp_valid_d = 1'b1;
              rsp_d       = pack_rsp(STAT_NOT_FOUND, 1'b0, '0, '0, COUNT_W'(count_q));
            end
          end

          CMD_REMOVE, CMD_DESTROY: begin
            if (here && (count_q != '0)) begin
              // last entry moves into the freed slot (self copy when it is last)
              sm_we    = 1'b1;
              sm_waddr = hit_slot;
              sm_wdata = sm_rdata_q;
              em_we    = 1'b1;
              em_waddr = moved_ent;
              em_wdata = {1'b1, hit_slot};
              count_d  = count_q - 1'b1;
              state_d  = ST_MOVE;
            end else begin
              state_d     = ST_IDLE;
              rsp_valid_d = 1'b1;
              rsp_d       = pack_rsp((cmd_q == CMD_REMOVE) ? STAT_NOT_FOUND : STAT_DONE,
                                     1'b0, '0, '0, COUNT_W'(count_q));
            end
          end

          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_VALUE: begin
        state_d     = ST_IDLE;
        rsp_valid_d = 1'b1;
        rsp_d       = pack_rsp(STAT_DONE, 1'b1, VALUE_W'(moved_val), SLOT_W'(slot_q),
                               COUNT_W'(count_q));
      end

      ST_MOVE: begin
        // clear the removed entity after the moved one is patched
        em_we       = 1'b1;
        em_waddr    = ent_q;
        em_wdata    = {1'b0, slot_q};
        state_d     = ST_IDLE;
        rsp_valid_d = 1'b1;
        rsp_d       = pack_rsp(STAT_DONE, 1'b1, '0, SLOT_W'(slot_q), COUNT_W'(count_q));
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // request capture and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= req_i.command;
      ent_q      <= IW'(req_i.entity);
      val_q      <= VALUE_BITS'(req_i.value_in);
      in_range_q <= in_range;
    end
    slot_q <= slot_d;
    rsp_q  <= rsp_d;
  end

  // slot store, read data registered
  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      slot_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata_q <= slot_mem[sm_raddr];
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `DCT_NEVER(a_no_result_in_clear, clk_i, rst_ni, clearing && rsp_valid_o,
             "result during clearing sweep")
  `DCT_ASSERT(a_result_after_work, clk_i, rst_ni,
              rsp_valid_o |-> $past(state_q != ST_IDLE),
              "result without a request in flight")
  `DCT_ASSERT(a_count_step, clk_i, rst_ni,
              (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
              (count_q + 1'b1 == $past(count_q)),
              "count moved by more than one")
  `DCT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_ENTITIES),
              "count above table depth")
  `DCT_ASSERT(a_full_status, clk_i, rst_ni,
              rsp_valid_o && (rsp_o.status == STAT_FULL) |-> full,
              "full reported on a table with room")

endmodule
